>>> hdl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Types, constants and the digit-to-character map for the integer to ascii
// converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int VALUE_BITS = 32;
  localparam int RADIX_BITS = 6;
  localparam int DIGIT_BITS = 6;
  localparam int CHAR_BITS  = 8;

  localparam logic [RADIX_BITS-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_BITS-1:0] RADIX_DEC = 6'd10;

  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_A     = 8'h61;
  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_BITS-1:0] CHAR_NONE  = 8'h00;

  localparam logic [DIGIT_BITS-1:0] DIGIT_NINE = 6'd9;
  localparam logic [DIGIT_BITS-1:0] DIGIT_TEN  = 6'd10;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value_bits;
    logic [RADIX_BITS-1:0] radix;
    logic                  signed_mode;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_BITS-1:0] char_code;
    logic                 is_last;
    logic                 is_empty;
  } out_item_t;

  function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
    logic [CHAR_BITS-1:0] ch;
    if (d > DIGIT_NINE) begin
      ch = CHAR_A + CHAR_BITS'(d - DIGIT_TEN);
    end else begin
      ch = CHAR_ZERO + CHAR_BITS'(d);
    end
    return ch;
  endfunction

endpackage

>>> hdl/itoa_div.sv
// ----------------------------------------------------------------------------
// itoa_div
// Restoring divider, one quotient bit per cycle, dividing a value by a
// small base; gives quotient and remainder with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module itoa_div #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [VALUE_WIDTH-1:0]           dividend,
  input  logic [itoa_pkg::RADIX_BITS-1:0]  divisor,
  output logic                             done,
  output logic [VALUE_WIDTH-1:0]           quotient,
  output logic [itoa_pkg::DIGIT_BITS-1:0]  remainder
);
  import itoa_pkg::*;

  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic                    busy;
  logic [CW-1:0]           count;
  logic [VALUE_WIDTH-1:0]  dvd;
  logic [DIGIT_BITS-1:0]   rem;
  logic [RADIX_BITS-1:0]   dvs;
  logic [DIGIT_BITS:0]     trial;
  logic                    fits;

  // remainder stays below the base, so one extra bit holds the shifted trial
  assign trial = {rem, dvd[VALUE_WIDTH-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && !start && (count == CW'(1));
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(VALUE_WIDTH);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      dvd <= {dvd[VALUE_WIDTH-2:0], fits};
      if (fits) begin
        rem <= DIGIT_BITS'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[DIGIT_BITS-1:0];
      end
    end
  end

  assign quotient  = dvd;
  assign remainder = rem;

endmodule

>>> hdl/integer_to_ascii_radix.sv
// per digit the sequencer starts the shared divider (S_START) and waits for its done
// (S_WAIT); each character is then read (S_LOAD) and shown (S_SHOW), after a minus sign
// (S_SIGN) where one is due, while the output is free; one value is converted at a time,
// up to 32 digits for 32 bits in base 2; an invalid base gives one empty result (S_EMPTY)
// reset clears the sequencer, divider control and output valid; the digit
// store is not cleared and is written before every read
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Converts a value to ascii digits in base 2 to 36, most significant first,
// using one shared iterative divider and a small digit store.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix #(
  parameter int VALUE_WIDTH = 32,
  parameter int DIGIT_SLOTS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  itoa_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output itoa_pkg::out_item_t  out_data
);
  import itoa_pkg::*;

  localparam int AW = $clog2(DIGIT_SLOTS);
  localparam int CW = $clog2(DIGIT_SLOTS + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_START = 7'b0000010,
    S_WAIT  = 7'b0000100,
    S_SIGN  = 7'b0001000,
    S_LOAD  = 7'b0010000,
    S_SHOW  = 7'b0100000,
    S_EMPTY = 7'b1000000
  } state_t;

  state_t                   state;
  logic [VALUE_WIDTH-1:0]   quot;
  logic [CW-1:0]            cnt;
  logic [CW-1:0]            cnt_inc;
  logic [CW-1:0]            idx_m1;
  logic                     negative;
  logic [DIGIT_BITS-1:0]    mem [DIGIT_SLOTS];
  logic [DIGIT_BITS-1:0]    mem_q;

  logic                     div_start;
  logic                     div_done;
  logic [VALUE_WIDTH-1:0]   div_quot;
  logic [DIGIT_BITS-1:0]    div_rem;
  logic [RADIX_BITS-1:0]    radix;

  logic [VALUE_WIDTH+VALUE_BITS-1:0] value_ext;
  logic [VALUE_WIDTH-1:0]   value_in;
  logic                     radix_ok;
  logic                     neg_in;
  logic                     in_xfer;
  logic                     slot_free;
  logic                     emit;

  assign value_ext = {{VALUE_WIDTH{1'b0}}, in_data.value_bits};
  assign value_in  = value_ext[VALUE_WIDTH-1:0];
  assign radix_ok  = (in_data.radix >= RADIX_MIN) && (in_data.radix <= RADIX_MAX);
  assign neg_in    = in_data.signed_mode && (in_data.radix == RADIX_DEC) &&
                     value_in[VALUE_WIDTH-1];

  assign in_ready  = (state == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign emit      = slot_free && (state inside {S_SIGN, S_SHOW, S_EMPTY});
  assign div_start = (state == S_START);
  assign cnt_inc   = cnt + 1'b1;
  // cnt less one is the read index while emitting
  assign idx_m1    = cnt - 1'b1;

  itoa_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (quot),
    .divisor  (radix),
    .done     (div_done),
    .quotient (div_quot),
    .remainder(div_rem)
  );

  // digit store, least significant digit first
  always_ff @(posedge clk) begin
    if (state == S_WAIT && div_done) begin
      mem[cnt[AW-1:0]] <= div_rem;
    end
    mem_q <= mem[idx_m1[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      negative  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            cnt      <= '0;
            negative <= neg_in;
            state    <= radix_ok ? S_START : S_EMPTY;
          end
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            cnt <= cnt_inc;
            if (div_quot == '0 || cnt_inc == CW'(DIGIT_SLOTS)) begin
              state <= negative ? S_SIGN : S_LOAD;
            end else begin
              state <= S_START;
            end
          end
        end
        S_SIGN: begin
          if (slot_free) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          state <= S_SHOW;
        end
        S_SHOW: begin
          if (slot_free) begin
            cnt   <= idx_m1;
            state <= (cnt == CW'(1)) ? S_IDLE : S_LOAD;
          end
        end
        S_EMPTY: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      radix <= in_data.radix;
      quot  <= neg_in ? VALUE_WIDTH'(~value_in + 1'b1) : value_in;
    end else if (state == S_WAIT && div_done) begin
      quot <= div_quot;
    end
    if (slot_free) begin
      case (state)
        S_SIGN: begin
          out_data <= '{char_code: CHAR_MINUS, is_last: 1'b0, is_empty: 1'b0};
        end
        S_SHOW: begin
          out_data <= '{char_code: digit_char(mem_q), is_last: (cnt == CW'(1)),
                        is_empty: 1'b0};
        end
        S_EMPTY: begin
          out_data <= '{char_code: CHAR_NONE, is_last: 1'b1, is_empty: 1'b1};
        end
        default: begin
          out_data <= out_data;
        end
      endcase
    end
  end

endmodule

>>> hdl/itoa_chk.sv
// ----------------------------------------------------------------------------
// itoa_chk
// Port-level checks for the integer to ascii converter, bound to the top.
// ----------------------------------------------------------------------------
module itoa_chk (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input itoa_pkg::in_item_t   in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input itoa_pkg::out_item_t  out_data
);
  import itoa_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // after a transfer in, the block is busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // an empty result is a single last character of code zero
  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_empty |-> out_data.is_last &&
      out_data.char_code == CHAR_NONE)
    else $error("malformed empty result");

  // a conversion in the middle of its output takes no new input
  a_no_accept_mid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.is_last |-> !in_ready)
    else $error("input ready before last character");

endmodule

bind integer_to_ascii_radix itoa_chk u_itoa_chk (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives values, bases and sign modes into the integer to ascii converter and
// checks every emitted character against typed text or a behavioral conversion: a directed
// table first, then random values, under changing idle patterns on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import itoa_pkg::*;

  localparam int DIGIT_SLOTS    = 32;
  localparam int DIRECTED_ROWS  = 24;
  localparam int RANDOM_ITEMS   = 196;
  localparam int TOTAL_ITEMS    = DIRECTED_ROWS + RANDOM_ITEMS;
  localparam int REPORT_LIMIT   = 10;
  localparam int SETTLE_CYCLES  = 200;

  logic      clk;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  integer_to_ascii_radix dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("tb_top failed");
    $finish;
  end

  // directed rows; typed rows carry the expected text, an empty text means
  // the single empty result of an invalid base
  in_item_t directed_items [DIRECTED_ROWS] = '{
    '{32'h0000_0000, 6'd10, 1'b0},
    '{32'h0000_0000, 6'd2,  1'b1},
    '{32'hffff_ffff, 6'd16, 1'b0},
    '{32'hffff_ffff, 6'd10, 1'b0},
    '{32'hffff_ffff, 6'd10, 1'b1},
    '{32'h8000_0000, 6'd10, 1'b1},
    '{32'h7fff_ffff, 6'd10, 1'b1},
    '{32'hffff_ffff, 6'd2,  1'b0},
    '{32'h8000_0000, 6'd16, 1'b1},
    '{32'd35,        6'd36, 1'b0},
    '{32'hffff_ffff, 6'd36, 1'b0},
    '{32'h0000_0000, 6'd0,  1'b0},
    '{32'd12345,     6'd1,  1'b1},
    '{32'hffff_ffff, 6'd37, 1'b0},
    '{32'hffff_ffff, 6'd63, 1'b1},
    '{32'd255,       6'd8,  1'b0},
    '{32'h1234_5678, 6'd16, 1'b1},
    '{32'd10,        6'd10, 1'b1},
    '{32'd9,         6'd10, 1'b0},
    '{32'hffff_ffff, 6'd3,  1'b1},
    '{32'haaaa_aaaa, 6'd2,  1'b0},
    '{32'h5555_5555, 6'd2,  1'b1},
    '{32'd1,         6'd36, 1'b1},
    '{32'h8000_0000, 6'd10, 1'b0}
  };
  bit directed_typed [DIRECTED_ROWS] = '{
    1, 1, 1, 1, 1, 1, 1, 0, 1, 1, 0, 1,
    1, 1, 1, 0, 1, 1, 1, 0, 0, 0, 1, 1
  };
  string directed_text [DIRECTED_ROWS] = '{
    "0", "0", "ffffffff", "4294967295", "-1", "-2147483648", "2147483647", "",
    "80000000", "z", "", "", "", "", "", "", "12345678", "10", "9", "", "", "",
    "1", "2147483648"
  };

  string glyphs = "0123456789abcdefghijklmnopqrstuvwxyz";

  // conversion state
  logic [VALUE_BITS-1:0] quotient;
  logic [DIGIT_BITS-1:0] digits [DIGIT_SLOTS];
  int                    digit_total;
  logic                  minus_flag;

  out_item_t expected_chars [$];
  int        mismatch_count = 0;
  int        send_idle_pct  = 0;
  int        recv_idle_pct  = 0;

  function automatic void predict_text(input in_item_t item);
    logic [VALUE_BITS-1:0] magnitude;
    out_item_t             ch;
    int                    i;
    if (item.radix < RADIX_MIN || item.radix > RADIX_MAX) begin
      expected_chars.push_back('{CHAR_NONE, 1'b1, 1'b1});
      return;
    end
    minus_flag = item.signed_mode && item.radix == RADIX_DEC &&
                 item.value_bits[VALUE_BITS-1];
    magnitude = minus_flag ? -item.value_bits : item.value_bits;
    digit_total = 0;
    quotient = magnitude;
    if (magnitude == '0) begin
      digits[0] = '0;
      digit_total = 1;
    end
    while (quotient != '0 && digit_total < DIGIT_SLOTS) begin
      digits[digit_total] = DIGIT_BITS'(quotient % VALUE_BITS'(item.radix));
      digit_total++;
      quotient = quotient / VALUE_BITS'(item.radix);
    end
    quotient = '0;
    if (minus_flag) begin
      expected_chars.push_back('{CHAR_MINUS, 1'b0, 1'b0});
    end
    for (i = digit_total - 1; i >= 0; i--) begin
      ch.char_code = glyphs[digits[i]];
      ch.is_last   = (i == 0);
      ch.is_empty  = 1'b0;
      expected_chars.push_back(ch);
    end
  endfunction

  function automatic void push_typed(input string text);
    out_item_t ch;
    int        i;
    if (text.len() == 0) begin
      expected_chars.push_back('{CHAR_NONE, 1'b1, 1'b1});
      return;
    end
    for (i = 0; i < text.len(); i++) begin
      ch.char_code = text[i];
      ch.is_last   = (i == text.len() - 1);
      ch.is_empty  = 1'b0;
      expected_chars.push_back(ch);
    end
  endfunction

  function automatic in_item_t random_item();
    in_item_t    item;
    int          pick;
    logic [63:0] power;
    pick = $urandom_range(99);
    if (pick < 8) begin
      item.radix = $urandom_range(1) ? 6'($urandom_range(37, 63)) : 6'($urandom_range(1));
    end else if (pick < 40) begin
      item.radix = RADIX_DEC;
    end else if (pick < 55) begin
      case ($urandom_range(2))
        0:       item.radix = 6'd2;
        1:       item.radix = 6'd8;
        default: item.radix = 6'd16;
      endcase
    end else begin
      item.radix = 6'($urandom_range(2, 36));
    end
    item.signed_mode = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 15) begin
      item.value_bits = $urandom_range(40);
    end else if (pick < 25) begin
      case ($urandom_range(4))
        0:       item.value_bits = 32'h0000_0000;
        1:       item.value_bits = 32'hffff_ffff;
        2:       item.value_bits = 32'h8000_0000;
        3:       item.value_bits = 32'h7fff_ffff;
        default: item.value_bits = 32'h8000_0001;
      endcase
    end else if (pick < 40) begin
      item.value_bits = $urandom >> $urandom_range(31);
    end else if (pick < 55) begin
      // a power of the base or one below it, where the digit count steps
      power = 64'd1;
      repeat ($urandom_range(1, 31)) begin
        if (power * item.radix <= 64'hffff_ffff) power = power * item.radix;
      end
      item.value_bits = VALUE_BITS'(power - 64'($urandom_range(1)));
    end else begin
      item.value_bits = $urandom;
    end
    return item;
  endfunction

  function automatic void flag_error(input string msg);
    if (mismatch_count < REPORT_LIMIT) $display("mismatch: %s", msg);
    mismatch_count++;
  endfunction

  // returns at the edge where the transfer happens; valid stays high after it
  task automatic transfer_item(input in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    in_item_t item;
    int       n;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (n = 0; n < TOTAL_ITEMS; n++) begin
      if (n < TOTAL_ITEMS / 3) begin
        send_idle_pct = 30;
        recv_idle_pct = 49;
      end else if (n < 2 * TOTAL_ITEMS / 3) begin
        send_idle_pct = 49;
        recv_idle_pct = 30;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      item = (n < DIRECTED_ROWS) ? directed_items[n] : random_item();
      transfer_item(item);
      if (n < DIRECTED_ROWS && directed_typed[n]) begin
        push_typed(directed_text[n]);
      end else begin
        predict_text(item);
      end
    end
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // output side: check each transfer, then pick the next ready value
  initial begin
    out_item_t want;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          flag_error($sformatf("unexpected char %h last %b empty %b",
                               out_data.char_code, out_data.is_last, out_data.is_empty));
        end else begin
          want = expected_chars.pop_front();
          if (out_data.char_code !== want.char_code || out_data.is_last !== want.is_last ||
              out_data.is_empty !== want.is_empty) begin
            flag_error($sformatf("expected char %h last %b empty %b, got char %h last %b empty %b",
                                 want.char_code, want.is_last, want.is_empty,
                                 out_data.char_code, out_data.is_last, out_data.is_empty));
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

endmodule
